// File: sv/paged_cache_page_allocator_macros.svh
// Assertion helpers; clk and arst_n come from the module that expands them.
`ifndef PAGED_CACHE_PAGE_ALLOCATOR_MACROS_SVH
`define PAGED_CACHE_PAGE_ALLOCATOR_MACROS_SVH

`define CPA_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define CPA_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: sv/cpa_pkg.sv
`default_nettype none
package cpa_pkg;
	localparam int MAX_PAGES         = 1024;
	localparam int MAX_SEQUENCES     = 64;
	localparam int MAX_PAGES_PER_SEQ = 32;

	localparam int PAGE_W   = $clog2(MAX_PAGES);
	localparam int CNT_W    = PAGE_W + 1;
	localparam int SLOT_W   = $clog2(MAX_SEQUENCES);
	localparam int SEQCNT_W = SLOT_W + 1;
	localparam int PIDX_W   = $clog2(MAX_PAGES_PER_SEQ);
	localparam int PCNT_W   = PIDX_W + 1;
	localparam int TOK_W    = 24;
	localparam int ID_W     = 64;
	localparam int PS_W     = 17;
	localparam int NEED_W   = TOK_W + 1;
	localparam int MODE_W   = 3;
	localparam int STATUS_W = 3;
	localparam int PS_MAX   = 65536;

	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_OK         = 3'd0;
	localparam status_t ST_BAD_ID     = 3'd1;
	localparam status_t ST_DUP        = 3'd2;
	localparam status_t ST_NOT_FOUND  = 3'd3;
	localparam status_t ST_NO_PAGES   = 3'd4;
	localparam status_t ST_SLOTS_FULL = 3'd5;
	localparam status_t ST_OVER       = 3'd6;
	localparam status_t ST_NOT_READY  = 3'd7;

	typedef logic [MODE_W-1:0] mode_t;
	localparam mode_t MODE_RESERVE = 3'd0;
	localparam mode_t MODE_GROW    = 3'd1;
	localparam mode_t MODE_COMMIT  = 3'd2;
	localparam mode_t MODE_RELEASE = 3'd3;
	localparam mode_t MODE_QUERY   = 3'd4;
	localparam mode_t MODE_DUMP    = 3'd5;
	localparam mode_t MODE_STATS   = 3'd6;
	localparam mode_t MODE_SPARE   = 3'd7;

	localparam logic REG_TOTAL_PAGES = 1'b0;
	localparam logic REG_PAGE_SIZE   = 1'b1;

	typedef struct packed {
		logic init;
		logic pop;
		logic push;
	} free_ctl_t;
endpackage
`default_nettype wire

// File: sv/cpa_div.sv
`default_nettype none
module cpa_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [cpa_pkg::TOK_W-1:0] dividend,
	input  wire logic [cpa_pkg::PS_W-1:0]  divisor,
	output logic                           done,
	output logic [cpa_pkg::NEED_W-1:0]     need
);
	import cpa_pkg::*;

	localparam int STEP_W = $clog2(TOK_W);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [PS_W-1:0]   rem_q;
	logic [TOK_W-1:0]  quo_q;
	logic [PS_W-1:0]   dvs_q;
	logic [PS_W:0]     trial;
	logic              fits;

	assign trial = {rem_q, quo_q[TOK_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign done  = !busy_q;
	assign need  = {1'b0, quo_q} + NEED_W'(rem_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(TOK_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? PS_W'(trial - {1'b0, dvs_q}) : trial[PS_W-1:0];
			quo_q <= {quo_q[TOK_W-2:0], fits};
		end
	end
endmodule
`default_nettype wire

// File: sv/cpa_free.sv
`default_nettype none
module cpa_free (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cpa_pkg::free_ctl_t         ctl,
	input  wire logic [cpa_pkg::CNT_W-1:0]  init_total,
	input  wire logic [cpa_pkg::PAGE_W-1:0] push_data,
	output logic [cpa_pkg::PAGE_W-1:0]      pop_data,
	output logic [cpa_pkg::CNT_W-1:0]       count
);
	import cpa_pkg::*;

	logic [PAGE_W-1:0] fifo_mem [MAX_PAGES];
	logic [PAGE_W-1:0] head_q, tail_q, tail0_q;
	logic [CNT_W-1:0]  count_q, wcnt_q;
	logic [PAGE_W-1:0] rd_s1, idx_s1;
	logic              wr_s1;
	logic [PAGE_W-1:0] head_off;
	logic              written;

	assign head_off = head_q - tail0_q;
	assign written  = {1'b0, head_off} < wcnt_q;
	assign pop_data = wr_s1 ? rd_s1 : idx_s1;
	assign count    = count_q;

	always_ff @(posedge clk) begin
		if (ctl.push)
			fifo_mem[tail_q] <= push_data;
		if (ctl.pop) begin
			rd_s1  <= fifo_mem[head_q];
			idx_s1 <= head_q;
			wr_s1  <= written;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			tail0_q <= '0;
			count_q <= '0;
			wcnt_q  <= '0;
		end else if (ctl.init) begin
			head_q  <= '0;
			tail_q  <= init_total[PAGE_W-1:0];
			tail0_q <= init_total[PAGE_W-1:0];
			count_q <= init_total;
			wcnt_q  <= '0;
		end else begin
			if (ctl.pop) begin
				head_q  <= head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (ctl.push) begin
				tail_q <= tail_q + 1'b1;
				if (count_q < CNT_W'(MAX_PAGES))
					count_q <= count_q + 1'b1;
				if (wcnt_q < CNT_W'(MAX_PAGES))
					wcnt_q <= wcnt_q + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// File: sv/paged_cache_page_allocator.sv
// Stats and not-ready answers go straight to the output; other modes first
// run a 64-slot key scan through the key memory, then move pages as needed.
// Page-table dump sends one word at a time; allocation and release 1 page per cycle.
// One operation at a time: no new request is taken until the last answer is sent.
// Reset: pool not initialized (total_pages 0), page_size 16, no live sequences.
`default_nettype none
`include "paged_cache_page_allocator_macros.svh"
module paged_cache_page_allocator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [87:0] s_axis_tdata,  // sequence_id[63:0], token_count[87:64]
	input  wire logic [2:0]  s_axis_tuser,  // mode[2:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// status[2:0], length[26:3], page[36:27], free_pages[47:37], used_pages[58:48],
	// sequence_count[65:59], page_count[71:66]
	output logic [71:0]      m_axis_tdata,
	output logic             m_axis_tuser,  // page_valid[0]
	output logic             m_axis_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [16:0] cfg_data
);
	import cpa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SEARCH, S_META, S_DECIDE, S_ALLOC, S_FIN, S_REL,
		S_DUMP_RD, S_DUMP_OUT, S_OUT
	} state_t;

	typedef struct packed {
		logic [TOK_W-1:0]  len;
		logic [PCNT_W-1:0] pages;
	} meta_t;

	localparam int PT_W = SLOT_W + PIDX_W;

	state_t state_q;

	logic [ID_W-1:0]   key_mem  [MAX_SEQUENCES];
	meta_t             meta_mem [MAX_SEQUENCES];
	logic [PAGE_W-1:0] pt_mem   [MAX_SEQUENCES * MAX_PAGES_PER_SEQ];

	logic [CNT_W-1:0]   total_q;
	logic [PS_W-1:0]    psize_q;
	logic [MAX_SEQUENCES-1:0] slot_valid_q;
	logic [SEQCNT_W-1:0] live_q;

	mode_t              mode_q;
	logic [ID_W-1:0]    id_q;
	logic [TOK_W-1:0]   tok_q;
	logic [SEQCNT_W-1:0] scan_q;
	logic [SLOT_W-1:0]  sidx_s1;
	logic               spv_s1;
	logic [ID_W-1:0]    key_rd_s1;
	meta_t              meta_rd_s1;
	logic               hit_q, free_found_q;
	logic [SLOT_W-1:0]  slot_q, free_slot_q, tgt_q;
	logic [PCNT_W-1:0]  have_q, pc_q, i_q;
	logic [TOK_W-1:0]   len_q, len_new_q;
	logic [PIDX_W-1:0]  aidx_s1;
	logic               apv_s1, rpv_s1;
	logic [PAGE_W-1:0]  pt_rd_s1;

	status_t            ostat_q;
	logic [TOK_W-1:0]   olen_q;
	logic [PCNT_W-1:0]  opc_q;
	logic               opv_q, olast_q;

	logic               in_acc;
	logic               cfg_total, cfg_psize;
	logic [CNT_W-1:0]   total_d;
	logic [PS_W-1:0]    psize_d;
	logic               key_re, pt_re, pop;
	logic [PT_W-1:0]    pt_raddr;
	free_ctl_t          free_ctl;
	logic [PAGE_W-1:0]  free_pop_data;
	logic [CNT_W-1:0]   free_cnt;
	logic               div_done;
	logic [NEED_W-1:0]  div_need;
	logic [PCNT_W-1:0]  have_d, need6;
	logic               over, grows, lack;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign cfg_total = cfg_we && (cfg_index == REG_TOTAL_PAGES);
	assign cfg_psize = cfg_we && (cfg_index == REG_PAGE_SIZE);
	assign total_d   = (cfg_data > 17'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : cfg_data[CNT_W-1:0];
	assign psize_d   = (cfg_data == '0) ? PS_W'(1) :
	                   (cfg_data > 17'(PS_MAX)) ? PS_W'(PS_MAX) : cfg_data;

	assign key_re   = (state_q == S_SEARCH) && (scan_q < SEQCNT_W'(MAX_SEQUENCES));
	assign pop      = (state_q == S_ALLOC) && (i_q < pc_q);
	assign pt_re    = ((state_q == S_REL) && (i_q < have_q)) || (state_q == S_DUMP_RD);
	assign pt_raddr = {tgt_q, i_q[PIDX_W-1:0]};

	assign free_ctl.init = cfg_total;
	assign free_ctl.pop  = pop;
	assign free_ctl.push = rpv_s1;

	assign have_d = (mode_q == MODE_RESERVE) ? '0 : meta_rd_s1.pages;
	assign need6  = div_need[PCNT_W-1:0];
	assign over   = div_need > NEED_W'(MAX_PAGES_PER_SEQ);
	assign grows  = div_need > NEED_W'(have_d);
	assign lack   = CNT_W'(PCNT_W'(need6 - have_d)) > free_cnt;

	cpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_acc),
		.dividend (s_axis_tdata[87:64]),
		.divisor  (psize_q),
		.done     (div_done),
		.need     (div_need)
	);

	cpa_free u_free (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (free_ctl),
		.init_total (total_d),
		.push_data  (pt_rd_s1),
		.pop_data   (free_pop_data),
		.count      (free_cnt)
	);

	always_ff @(posedge clk) begin
		if (key_re)
			key_rd_s1 <= key_mem[scan_q[SLOT_W-1:0]];
		if (state_q == S_FIN && mode_q == MODE_RESERVE)
			key_mem[tgt_q] <= id_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_META)
			meta_rd_s1 <= meta_mem[slot_q];
		if (state_q == S_FIN)
			meta_mem[tgt_q] <= '{len: len_new_q, pages: pc_q};
	end

	always_ff @(posedge clk) begin
		if (pt_re)
			pt_rd_s1 <= pt_mem[pt_raddr];
		if (apv_s1)
			pt_mem[{tgt_q, aidx_s1}] <= free_pop_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			psize_q <= PS_W'(16);
		end else begin
			if (cfg_total)
				total_q <= total_d;
			if (cfg_psize)
				psize_q <= psize_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= s_axis_tuser;
			id_q   <= s_axis_tdata[63:0];
			tok_q  <= s_axis_tdata[87:64];
		end
		if (key_re)
			sidx_s1 <= scan_q[SLOT_W-1:0];
		if (pop)
			aidx_s1 <= i_q[PIDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_valid_q <= '0;
			live_q       <= '0;
			scan_q       <= '0;
			spv_s1       <= 1'b0;
			apv_s1       <= 1'b0;
			rpv_s1       <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			slot_q       <= '0;
			free_slot_q  <= '0;
			tgt_q        <= '0;
			have_q       <= '0;
			pc_q         <= '0;
			i_q          <= '0;
			len_q        <= '0;
			len_new_q    <= '0;
			ostat_q      <= ST_OK;
			olen_q       <= '0;
			opc_q        <= '0;
			opv_q        <= 1'b0;
			olast_q      <= 1'b0;
		end else begin
			spv_s1 <= key_re;
			apv_s1 <= pop;
			rpv_s1 <= (state_q == S_REL) && (i_q < have_q);
			if (cfg_total) begin
				slot_valid_q <= '0;
				live_q       <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						opv_q   <= 1'b0;
						olast_q <= 1'b1;
						olen_q  <= '0;
						opc_q   <= '0;
						if (s_axis_tuser == MODE_STATS || s_axis_tuser == MODE_SPARE) begin
							ostat_q <= ST_OK;
							state_q <= S_OUT;
						end else if (total_q == '0) begin
							ostat_q <= ST_NOT_READY;
							state_q <= S_OUT;
						end else begin
							scan_q       <= '0;
							hit_q        <= 1'b0;
							free_found_q <= 1'b0;
							state_q      <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (key_re)
						scan_q <= scan_q + 1'b1;
					if (spv_s1) begin
						if (slot_valid_q[sidx_s1] && key_rd_s1 == id_q) begin
							hit_q  <= 1'b1;
							slot_q <= sidx_s1;
						end
						if (!slot_valid_q[sidx_s1] && !free_found_q) begin
							free_found_q <= 1'b1;
							free_slot_q  <= sidx_s1;
						end
					end
					if (!key_re && !spv_s1)
						state_q <= S_META;
				end
				S_META: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (div_done) begin
						have_q  <= have_d;
						len_q   <= meta_rd_s1.len;
						tgt_q   <= (mode_q == MODE_RESERVE) ? free_slot_q : slot_q;
						ostat_q <= ST_OK;
						olen_q  <= '0;
						opc_q   <= '0;
						state_q <= S_OUT;
						unique case (mode_q)
							MODE_RESERVE: begin
								if (id_q == '0)
									ostat_q <= ST_BAD_ID;
								else if (hit_q)
									ostat_q <= ST_DUP;
								else if (over)
									ostat_q <= ST_OVER;
								else if (!free_found_q)
									ostat_q <= ST_SLOTS_FULL;
								else if (lack)
									ostat_q <= ST_NO_PAGES;
								else begin
									i_q       <= '0;
									pc_q      <= need6;
									len_new_q <= '0;
									state_q   <= S_ALLOC;
								end
							end
							MODE_GROW, MODE_COMMIT: begin
								if (!hit_q)
									ostat_q <= ST_NOT_FOUND;
								else if (!grows) begin
									pc_q      <= have_d;
									len_new_q <= (mode_q == MODE_COMMIT) ? tok_q
									             : meta_rd_s1.len;
									state_q   <= S_FIN;
								end else if (over || lack) begin
									ostat_q <= over ? ST_OVER : ST_NO_PAGES;
									olen_q  <= meta_rd_s1.len;
									opc_q   <= have_d;
								end else begin
									i_q       <= have_d;
									pc_q      <= need6;
									len_new_q <= (mode_q == MODE_COMMIT) ? tok_q
									             : meta_rd_s1.len;
									state_q   <= S_ALLOC;
								end
							end
							MODE_RELEASE: begin
								if (!hit_q)
									ostat_q <= ST_NOT_FOUND;
								else begin
									i_q     <= '0;
									state_q <= S_REL;
								end
							end
							MODE_QUERY: begin
								if (!hit_q)
									ostat_q <= ST_NOT_FOUND;
								else begin
									olen_q <= meta_rd_s1.len;
									opc_q  <= have_d;
								end
							end
							MODE_DUMP: begin
								if (!hit_q)
									ostat_q <= ST_NOT_FOUND;
								else if (have_d == '0)
									olen_q <= meta_rd_s1.len;
								else begin
									i_q     <= '0;
									state_q <= S_DUMP_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_ALLOC: begin
					if (pop)
						i_q <= i_q + 1'b1;
					else if (!apv_s1)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (mode_q == MODE_RESERVE) begin
						slot_valid_q[tgt_q] <= 1'b1;
						live_q              <= live_q + 1'b1;
					end
					ostat_q <= ST_OK;
					olen_q  <= len_new_q;
					opc_q   <= pc_q;
					state_q <= S_OUT;
				end
				S_REL: begin
					if (i_q < have_q)
						i_q <= i_q + 1'b1;
					else if (!rpv_s1) begin
						slot_valid_q[tgt_q] <= 1'b0;
						live_q              <= live_q - 1'b1;
						ostat_q             <= ST_OK;
						state_q             <= S_OUT;
					end
				end
				S_DUMP_RD: begin
					ostat_q <= ST_OK;
					olen_q  <= len_q;
					opc_q   <= have_q;
					opv_q   <= 1'b1;
					olast_q <= (i_q + 1'b1) == have_q;
					state_q <= S_DUMP_OUT;
				end
				S_DUMP_OUT: begin
					if (m_axis_tready) begin
						i_q     <= i_q + 1'b1;
						state_q <= olast_q ? S_IDLE : S_DUMP_RD;
					end
				end
				S_OUT: begin
					if (m_axis_tready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT) || (state_q == S_DUMP_OUT);
	assign m_axis_tuser  = opv_q;
	assign m_axis_tlast  = olast_q;
	assign m_axis_tdata  = {opc_q, live_q, CNT_W'(total_q - free_cnt), free_cnt,
	                        opv_q ? pt_rd_s1 : PAGE_W'(0), olen_q, ostat_q};

	`CPA_ASSERT(a_free_bound, free_cnt <= total_q, "free count above pool size")
	`CPA_ASSERT(a_live_count, $countones(slot_valid_q) == int'(live_q), "live count drift")
	`CPA_IMPLY(a_one_side, s_axis_tready, !m_axis_tvalid, "input open while result pending")
	`CPA_IMPLY(a_pop_nonempty, pop, free_cnt != '0, "pop from empty free list")
endmodule
`default_nettype wire

// File: tb/sv/paged_cache_page_allocator_tb.sv
`default_nettype none
module paged_cache_page_allocator_tb;
	import cpa_pkg::*;

	typedef struct {
		mode_t       mode;
		logic [63:0] id;
		logic [23:0] tokens;
	} request_t;

	typedef struct {
		status_t     status;
		logic [23:0] length;
		logic [9:0]  page;
		logic        page_valid;
		logic        last;
		logic [10:0] free_pages;
		logic [10:0] used_pages;
		logic [6:0]  seq_count;
		logic [5:0]  page_count;
	} answer_t;

	localparam int IDLE_LIMIT = 6000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic        cfg_index;
	logic [16:0] cfg_data;

	paged_cache_page_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	request_t    pending_reqs[$];
	answer_t     expected_answers[$];
	request_t    cur_req;
	logic [63:0] key_pool[8];

	int unsigned free_list[MAX_PAGES];
	int unsigned free_head, free_tail, free_count;
	int unsigned pool_total, page_tokens;
	bit          slot_live[MAX_SEQUENCES];
	logic [63:0] slot_id[MAX_SEQUENCES];
	int unsigned slot_len[MAX_SEQUENCES];
	int unsigned slot_pg[MAX_SEQUENCES];
	int unsigned page_map[MAX_SEQUENCES*MAX_PAGES_PER_SEQ];

	int  send_idle_pct, recv_idle_pct;
	int  recv_hold;
	bit  req_fire;
	int  quiet_cycles;
	int  errors, words_in, words_out, dump_words;

	function automatic int find_seq(logic [63:0] key);
		for (int s = 0; s < MAX_SEQUENCES; s++)
			if (slot_live[s] && slot_id[s] == key)
				return s;
		return -1;
	endfunction

	function automatic int unsigned live_seqs();
		int unsigned n;
		n = 0;
		for (int s = 0; s < MAX_SEQUENCES; s++)
			if (slot_live[s])
				n++;
		return n;
	endfunction

	function automatic int unsigned pages_for(int unsigned tokens);
		return (tokens + page_tokens - 1) / page_tokens;
	endfunction

	function automatic void clear_pool();
		for (int s = 0; s < MAX_SEQUENCES; s++) begin
			slot_live[s] = 0;
			slot_pg[s] = 0;
			slot_len[s] = 0;
		end
		for (int i = 0; i < MAX_PAGES; i++)
			free_list[i] = (i < pool_total) ? i : 0;
		free_head = 0;
		free_tail = pool_total % MAX_PAGES;
		free_count = pool_total;
	endfunction

	function automatic void apply_config(logic idx, logic [16:0] value);
		if (idx == REG_TOTAL_PAGES) begin
			pool_total = (value > MAX_PAGES) ? MAX_PAGES : value;
			clear_pool();
		end else if (value == 0)
			page_tokens = 1;
		else if (value > PS_MAX)
			page_tokens = PS_MAX;
		else
			page_tokens = value;
	endfunction

	function automatic status_t grow_seq(int s, int unsigned tokens);
		int unsigned need;
		need = pages_for(tokens);
		if (need <= slot_pg[s])
			return ST_OK;
		if (need > MAX_PAGES_PER_SEQ)
			return ST_OVER;
		if (need - slot_pg[s] > free_count)
			return ST_NO_PAGES;
		for (int unsigned i = slot_pg[s]; i < need; i++) begin
			page_map[s*MAX_PAGES_PER_SEQ + i] = free_list[free_head];
			free_head = (free_head + 1) % MAX_PAGES;
			free_count--;
		end
		slot_pg[s] = need;
		return ST_OK;
	endfunction

	function automatic void push_answer(status_t st, int s, int unsigned page, bit pv, bit last);
		answer_t a;
		a.status = st;
		a.length = (s >= 0) ? slot_len[s] : 0;
		a.page = page;
		a.page_valid = pv;
		a.last = last;
		a.free_pages = free_count;
		a.used_pages = pool_total - free_count;
		a.seq_count = live_seqs();
		a.page_count = (s >= 0) ? slot_pg[s] : 0;
		expected_answers.push_back(a);
	endfunction

	function automatic void predict_answers(request_t r);
		int s, fs;
		int unsigned n;
		status_t st;
		if (r.mode == MODE_STATS || r.mode == MODE_SPARE) begin
			push_answer(ST_OK, -1, 0, 0, 1);
			return;
		end
		if (pool_total == 0) begin
			push_answer(ST_NOT_READY, -1, 0, 0, 1);
			return;
		end
		if (r.mode == MODE_RESERVE) begin
			fs = -1;
			for (int k = MAX_SEQUENCES - 1; k >= 0; k--)
				if (!slot_live[k])
					fs = k;
			if (r.id == 0)
				push_answer(ST_BAD_ID, -1, 0, 0, 1);
			else if (find_seq(r.id) >= 0)
				push_answer(ST_DUP, -1, 0, 0, 1);
			else if (pages_for(r.tokens) > MAX_PAGES_PER_SEQ)
				push_answer(ST_OVER, -1, 0, 0, 1);
			else if (fs < 0)
				push_answer(ST_SLOTS_FULL, -1, 0, 0, 1);
			else if (pages_for(r.tokens) > free_count)
				push_answer(ST_NO_PAGES, -1, 0, 0, 1);
			else begin
				slot_pg[fs] = 0;
				slot_len[fs] = 0;
				void'(grow_seq(fs, r.tokens));
				slot_id[fs] = r.id;
				slot_live[fs] = 1;
				push_answer(ST_OK, fs, 0, 0, 1);
			end
			return;
		end
		s = find_seq(r.id);
		if (s < 0) begin
			push_answer(ST_NOT_FOUND, -1, 0, 0, 1);
			return;
		end
		case (r.mode)
			MODE_GROW: begin
				st = grow_seq(s, r.tokens);
				push_answer(st, s, 0, 0, 1);
			end
			MODE_COMMIT: begin
				st = grow_seq(s, r.tokens);
				if (st == ST_OK)
					slot_len[s] = r.tokens;
				push_answer(st, s, 0, 0, 1);
			end
			MODE_RELEASE: begin
				for (int unsigned i = 0; i < slot_pg[s]; i++) begin
					free_list[free_tail] = page_map[s*MAX_PAGES_PER_SEQ + i];
					free_tail = (free_tail + 1) % MAX_PAGES;
					if (free_count < MAX_PAGES)
						free_count++;
				end
				slot_live[s] = 0;
				slot_pg[s] = 0;
				slot_len[s] = 0;
				push_answer(ST_OK, -1, 0, 0, 1);
			end
			MODE_QUERY: push_answer(ST_OK, s, 0, 0, 1);
			default: begin
				n = slot_pg[s];
				if (n == 0)
					push_answer(ST_OK, s, 0, 0, 1);
				for (int unsigned i = 0; i < n; i++)
					push_answer(ST_OK, s, page_map[s*MAX_PAGES_PER_SEQ + i], 1, i + 1 == n);
			end
		endcase
	endfunction

	task automatic queue_req(mode_t m, logic [63:0] id, int unsigned tokens);
		request_t r;
		r.mode = m;
		r.id = id;
		r.tokens = tokens;
		pending_reqs.push_back(r);
	endtask

	task automatic queue_random(int count);
		int unsigned pick, span;
		mode_t m;
		logic [63:0] id;
		logic [23:0] tok;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) m = MODE_RESERVE;
			else if (pick < 40) m = MODE_GROW;
			else if (pick < 55) m = MODE_COMMIT;
			else if (pick < 70) m = MODE_RELEASE;
			else if (pick < 80) m = MODE_QUERY;
			else if (pick < 92) m = MODE_DUMP;
			else if (pick < 96) m = MODE_STATS;
			else m = MODE_SPARE;
			pick = $urandom_range(0, 99);
			if (pick < 90) id = key_pool[$urandom_range(0, 7)];
			else if (pick < 95) id = 0;
			else id = {$urandom, $urandom};
			span = 34 * page_tokens;
			if (span > 24'hFFFFFF) span = 24'hFFFFFF;
			tok = ($urandom_range(0, 99) < 85) ? $urandom_range(0, span) : $urandom;
			queue_req(m, id, tok);
		end
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || s_axis_tvalid || expected_answers.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [16:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		apply_config(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		if (!s_axis_tvalid || req_fire) begin
			if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				cur_req = pending_reqs.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {cur_req.tokens, cur_req.id};
				s_axis_tuser <= cur_req.mode;
			end else
				s_axis_tvalid <= 1'b0;
		end
		if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= $urandom_range(0, 99) >= recv_idle_pct;
	end

	always @(posedge clk) begin
		answer_t got, want;
		request_t r;
		req_fire <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			r.mode = s_axis_tuser;
			r.id = s_axis_tdata[63:0];
			r.tokens = s_axis_tdata[87:64];
			predict_answers(r);
			words_in++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			words_out++;
			got.status = m_axis_tdata[2:0];
			got.length = m_axis_tdata[26:3];
			got.page = m_axis_tdata[36:27];
			got.page_valid = m_axis_tuser;
			got.last = m_axis_tlast;
			got.free_pages = m_axis_tdata[47:37];
			got.used_pages = m_axis_tdata[58:48];
			got.seq_count = m_axis_tdata[65:59];
			got.page_count = m_axis_tdata[71:66];
			if (got.page_valid)
				dump_words++;
			if (expected_answers.size() == 0) begin
				errors++;
				$display("%0t: unexpected word %p", $time, got);
			end else begin
				want = expected_answers.pop_front();
				if (got.status != want.status)
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
				if (got.length != want.length)
					$display("%0t: length exp %0d got %0d", $time, want.length, got.length);
				if (got.page != want.page)
					$display("%0t: page exp %0d got %0d", $time, want.page, got.page);
				if (got.page_valid != want.page_valid)
					$display("%0t: page_valid exp %0d got %0d", $time, want.page_valid,
						got.page_valid);
				if (got.last != want.last)
					$display("%0t: last exp %0d got %0d", $time, want.last, got.last);
				if (got.free_pages != want.free_pages)
					$display("%0t: free_pages exp %0d got %0d", $time, want.free_pages,
						got.free_pages);
				if (got.used_pages != want.used_pages)
					$display("%0t: used_pages exp %0d got %0d", $time, want.used_pages,
						got.used_pages);
				if (got.seq_count != want.seq_count)
					$display("%0t: sequence_count exp %0d got %0d", $time, want.seq_count,
						got.seq_count);
				if (got.page_count != want.page_count)
					$display("%0t: page_count exp %0d got %0d", $time, want.page_count,
						got.page_count);
				if (got != want)
					errors++;
			end
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress, %0d words outstanding", $time, expected_answers.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [63:0] k1, k2, k3, k5;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TOTAL_PAGES;
		cfg_data = '0;
		req_fire = 1'b0;
		quiet_cycles = 0;
		recv_hold = 0;
		errors = 0;
		words_in = 0;
		words_out = 0;
		dump_words = 0;
		send_idle_pct = 16;
		recv_idle_pct = 74;
		pool_total = 0;
		page_tokens = 16;
		clear_pool();
		for (int i = 0; i < 8; i++)
			key_pool[i] = {$urandom, $urandom};
		key_pool[0] = '1;
		key_pool[1] = 64'd1;
		k1 = key_pool[0];
		k2 = key_pool[1];
		k3 = key_pool[2];
		k5 = key_pool[3];
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_req(MODE_RESERVE, k1, 100);
		queue_req(MODE_STATS, 0, 0);
		queue_req(MODE_SPARE, '1, 24'hFFFFFF);
		wait_idle();
		write_reg(REG_PAGE_SIZE, 16);
		write_reg(REG_TOTAL_PAGES, 40);
		queue_req(MODE_RESERVE, 0, 10);
		queue_req(MODE_RESERVE, k1, 100);
		queue_req(MODE_RESERVE, k1, 5);
		queue_req(MODE_RESERVE, k2, 513);
		queue_req(MODE_RESERVE, k2, 0);
		queue_req(MODE_GROW, k2, 40);
		queue_req(MODE_COMMIT, k2, 16);
		queue_req(MODE_COMMIT, k2, 600);
		queue_req(MODE_GROW, k1, 24'hFFFFFF);
		queue_req(MODE_GROW, k3, 10);
		queue_req(MODE_COMMIT, k1, 5);
		queue_req(MODE_QUERY, k1, 0);
		queue_req(MODE_QUERY, k3, 0);
		queue_req(MODE_DUMP, k1, 0);
		queue_req(MODE_DUMP, k2, 0);
		queue_req(MODE_RELEASE, k2, 0);
		queue_req(MODE_DUMP, k2, 0);
		queue_req(MODE_RELEASE, k3, 0);
		queue_req(MODE_RESERVE, k3, 512);
		queue_req(MODE_RESERVE, k5, 100);
		queue_req(MODE_GROW, k1, 512);
		queue_req(MODE_RESERVE, k5, 0);
		queue_req(MODE_DUMP, k5, 0);
		queue_req(MODE_DUMP, k3, 0);
		queue_req(MODE_RELEASE, k1, 0);
		wait_idle();
		write_reg(REG_TOTAL_PAGES, 0);
		queue_req(MODE_QUERY, k3, 0);
		queue_req(MODE_DUMP, k3, 0);
		wait_idle();

		write_reg(REG_PAGE_SIZE, 0);
		write_reg(REG_TOTAL_PAGES, 1024);
		queue_random(45);
		wait_idle();
		queue_random(45);
		wait_idle();

		send_idle_pct = 74;
		recv_idle_pct = 16;
		write_reg(REG_PAGE_SIZE, 17'h1FFFF);
		write_reg(REG_TOTAL_PAGES, 17'h1FFFF);
		queue_random(90);
		wait_idle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_PAGE_SIZE, 7);
		write_reg(REG_TOTAL_PAGES, 24);
		@(negedge clk);
		recv_hold = 400;
		queue_random(30);
		for (int i = 0; i <= MAX_SEQUENCES; i++)
			queue_req(MODE_RESERVE, {32'hA5A5_0000, i[31:0] + 32'd1}, 0);
		for (int i = 0; i <= MAX_SEQUENCES; i++)
			queue_req(MODE_RELEASE, {32'hA5A5_0000, i[31:0] + 32'd1}, 0);
		queue_random(40);
		wait_idle();

		$display("%0d requests sent, %0d words checked (%0d page-table entries)",
			words_in, words_out, dump_words);
		$display("covered all modes, status codes, register extremes and slot exhaustion");
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
